/* design/cbse_pkg.sv */
`default_nettype none

package cbse_pkg;

    localparam int CBSE_MAX_POINTS    = 64;
    localparam int CBSE_FRACTION_BITS = 16;

    // Item operations carried on the input tuser.
    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_MOVE     = 3'd1,
        OP_SET_CTL  = 3'd2,
        OP_EVAL     = 3'd3,
        OP_GRADIENT = 3'd4
    } cbse_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } cbse_status_t;

    // Source of the data written to the control table.
    typedef enum logic [1:0] {
        CW_ZERO = 2'd0,
        CW_SETC = 2'd1,
        CW_UNIT = 2'd2
    } cbse_ctl_wsel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_WR,
        S_MOVE_WR,
        S_SC_RD,
        S_SC_WR,
        S_EV_RD_A,
        S_EV_RD_B,
        S_EV_LOAD,
        S_EV_DIFF,
        S_EV_MUL,
        S_EV_ADD,
        S_EV_STORE,
        S_RC_RD_PREV,
        S_RC_RD_NEXT,
        S_RC_DIFF,
        S_RC_NORM,
        S_RC_SQ_MUL,
        S_RC_SQ_ACC,
        S_RC_SQRT_INIT,
        S_RC_SQRT,
        S_RC_DIV_INIT,
        S_RC_DIV,
        S_RC_DIV_END,
        S_RC_WR,
        S_FINISH
    } cbse_state_t;

    typedef struct packed {
        logic           capture;
        logic           rd_en;
        logic           pt_we;
        logic           ctl_we;
        cbse_ctl_wsel_t ctl_wsel;
        logic           hold;
        logic           rc_diff;
        logic           norm_rsh;
        logic           norm_lsh;
        logic           sq_mul;
        logic           sq_acc;
        logic           sqrt_init;
        logic           sqrt_step;
        logic           div_init;
        logic           div_step;
        logic           div_end;
        logic [1:0]     axis;
        logic           ev_load;
        logic           ev_diff;
        logic           ev_mul;
        logic           ev_add;
        logic [1:0]     pos;
        logic           ev_store;
        logic           grad;
        logic           load_out;
    } cbse_cmd_t;

    typedef struct packed {
        logic zero;
        logic rsh;
        logic lsh;
    } cbse_flags_t;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/cbse_dp.sv */
`default_nettype none

module cbse_dp import cbse_pkg::*; #(
    parameter int MAX_POINTS    = CBSE_MAX_POINTS,
    parameter int FRACTION_BITS = CBSE_FRACTION_BITS,
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  wire logic          aclk,
    input  wire logic [15:0]   s_fraction,
    input  wire logic [31:0]   s_x,
    input  wire logic [31:0]   s_y,
    input  wire logic [31:0]   s_z,
    input  wire cbse_cmd_t     cmd,
    input  wire logic [AW-1:0] rd_addr,
    input  wire logic [AW-1:0] wr_addr,
    output cbse_flags_t        flags,
    output logic [31:0]        out_x,
    output logic [31:0]        out_y,
    output logic [31:0]        out_z
);

    localparam logic signed [64:0] HALF = 65'sd1 <<< (FRACTION_BITS - 1);

    logic [15:0]        frac_reg;
    logic [95:0]        in_xyz_reg;
    logic [95:0]        pt_mem [MAX_POINTS];
    logic [95:0]        ctl_mem [MAX_POINTS];
    logic [95:0]        pt_rd_reg, ctl_rd_reg, hold_pt_reg, hold_ctl_reg;
    logic [32:0]        mag_reg [3];
    logic [2:0]         neg_reg;
    logic signed [64:0] prod_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        sq_n_reg, sq_r_reg, sq_bit_reg;
    logic [32:0]        rem_reg;
    logic [16:0]        numlo_reg, quo_reg;
    logic [31:0]        u_reg [3];
    logic signed [32:0] w_reg [4];
    logic signed [33:0] diff_reg;
    logic [31:0]        res_reg [3];
    logic [31:0]        out_x_reg, out_y_reg, out_z_reg;

    logic [FRACTION_BITS-1:0] t_val;
    logic signed [33:0]       mul_a;
    logic signed [30:0]       mul_b;
    logic signed [64:0]       prod_w;
    logic [95:0]              ctl_wdata;
    logic signed [32:0]       lerp_w;
    logic [63:0]              sq_t;
    logic [46:0]              num_w;
    logic [32:0]              rem2, len33;
    logic signed [31:0]       a0, c0, a1, c1;
    logic signed [32:0]       w0_sel, w1_sel;

    assign t_val = FRACTION_BITS'(frac_reg);

    always_comb begin
        if (cmd.sq_mul) begin
            mul_a = signed'({1'b0, mag_reg[cmd.axis]});
            mul_b = signed'({1'b0, mag_reg[cmd.axis][29:0]});
        end else begin
            mul_a = diff_reg;
            mul_b = signed'(31'(t_val));
        end
    end
    assign prod_w = mul_a * mul_b;

    always_comb begin
        ctl_wdata = '0;
        case (cmd.ctl_wsel)
            CW_SETC: begin
                for (int k = 0; k < 3; k++) begin
                    ctl_wdata[k*32 +: 32] = sat32(34'(signed'(in_xyz_reg[k*32 +: 32]))
                                                - 34'(signed'(pt_rd_reg[k*32 +: 32])));
                end
            end
            CW_UNIT: ctl_wdata = {u_reg[2], u_reg[1], u_reg[0]};
            default: ctl_wdata = '0;
        endcase
    end

    // Rounded step of one de Casteljau linear interpolation.
    assign lerp_w = w_reg[cmd.pos] + 33'((prod_reg + HALF) >>> FRACTION_BITS);

    assign a0 = signed'(hold_pt_reg[cmd.axis*32 +: 32]);
    assign c0 = signed'(hold_ctl_reg[cmd.axis*32 +: 32]);
    assign a1 = signed'(pt_rd_reg[cmd.axis*32 +: 32]);
    assign c1 = signed'(ctl_rd_reg[cmd.axis*32 +: 32]);
    assign w0_sel = w_reg[0];
    assign w1_sel = w_reg[1];

    assign sq_t  = sq_r_reg + sq_bit_reg;
    assign num_w = (47'(mag_reg[cmd.axis][29:0]) << 16) + 47'(sq_r_reg[31:1]);
    assign rem2  = {rem_reg[31:0], numlo_reg[16]};
    assign len33 = {1'b0, sq_r_reg[31:0]};

    always_comb begin
        flags.zero = (mag_reg[0] == '0) && (mag_reg[1] == '0) && (mag_reg[2] == '0);
        flags.rsh  = (|mag_reg[0][32:30]) || (|mag_reg[1][32:30]) || (|mag_reg[2][32:30]);
        flags.lsh  = !((|mag_reg[0][32:29]) || (|mag_reg[1][32:29])
                       || (|mag_reg[2][32:29]));
    end

    always_ff @(posedge aclk) begin
        if (cmd.pt_we) begin
            pt_mem[wr_addr] <= in_xyz_reg;
        end
        if (cmd.ctl_we) begin
            ctl_mem[wr_addr] <= ctl_wdata;
        end
        if (cmd.rd_en) begin
            pt_rd_reg  <= pt_mem[rd_addr];
            ctl_rd_reg <= ctl_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            frac_reg   <= s_fraction;
            in_xyz_reg <= {s_z, s_y, s_x};
            for (int k = 0; k < 3; k++) begin
                res_reg[k] <= '0;
            end
        end
        if (cmd.hold) begin
            hold_pt_reg  <= pt_rd_reg;
            hold_ctl_reg <= ctl_rd_reg;
        end
        if (cmd.rc_diff) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [32:0] v;
                v = 33'(signed'(pt_rd_reg[k*32 +: 32])) - 33'(signed'(hold_pt_reg[k*32 +: 32]));
                neg_reg[k] <= v[32];
                mag_reg[k] <= v[32] ? 33'(-v) : 33'(v);
                u_reg[k]   <= '0;
            end
            sum_reg <= '0;
        end
        if (cmd.norm_rsh) begin
            for (int k = 0; k < 3; k++) begin
                mag_reg[k] <= mag_reg[k] >> 1;
            end
        end
        if (cmd.norm_lsh) begin
            for (int k = 0; k < 3; k++) begin
                mag_reg[k] <= mag_reg[k] << 1;
            end
        end
        if (cmd.sq_mul || cmd.ev_mul) begin
            prod_reg <= prod_w;
        end
        if (cmd.sq_acc) begin
            sum_reg <= sum_reg + 64'(prod_reg);
        end
        if (cmd.sqrt_init) begin
            sq_n_reg   <= sum_reg;
            sq_r_reg   <= '0;
            sq_bit_reg <= 64'd1 << 62;
        end
        if (cmd.sqrt_step) begin
            if (sq_n_reg >= sq_t) begin
                sq_n_reg <= sq_n_reg - sq_t;
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end else begin
                sq_r_reg <= sq_r_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (cmd.div_init) begin
            rem_reg   <= 33'(num_w[46:17]);
            numlo_reg <= num_w[16:0];
            quo_reg   <= '0;
        end
        if (cmd.div_step) begin
            if (rem2 >= len33) begin
                rem_reg <= rem2 - len33;
                quo_reg <= {quo_reg[15:0], 1'b1};
            end else begin
                rem_reg <= rem2;
                quo_reg <= {quo_reg[15:0], 1'b0};
            end
            numlo_reg <= numlo_reg << 1;
        end
        if (cmd.div_end) begin
            u_reg[cmd.axis] <= neg_reg[cmd.axis] ? -(32'(quo_reg)) : 32'(quo_reg);
        end
        if (cmd.ev_load) begin
            w_reg[0] <= 33'(a0);
            w_reg[1] <= 33'(a0) + 33'(c0);
            w_reg[2] <= 33'(a1) - 33'(c1);
            w_reg[3] <= 33'(a1);
        end
        if (cmd.ev_diff) begin
            diff_reg <= 34'(w_reg[cmd.pos + 2'd1]) - 34'(w_reg[cmd.pos]);
        end
        if (cmd.ev_add) begin
            w_reg[cmd.pos] <= lerp_w;
        end
        if (cmd.ev_store) begin
            res_reg[cmd.axis] <= sat32(cmd.grad ? 34'(w1_sel) - 34'(w0_sel) : 34'(w0_sel));
        end
        if (cmd.load_out) begin
            out_x_reg <= res_reg[0];
            out_y_reg <= res_reg[1];
            out_z_reg <= res_reg[2];
        end
    end

    assign out_x = out_x_reg;
    assign out_y = out_y_reg;
    assign out_z = out_z_reg;

endmodule

`default_nettype wire

/* design/cbse_ctrl.sv */
`default_nettype none

module cbse_ctrl import cbse_pkg::*; #(
    parameter int MAX_POINTS = CBSE_MAX_POINTS,
    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int CW   = $clog2(MAX_POINTS + 1),
    localparam int CMPW = (CW > 6) ? CW : 6
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [2:0]    s_op,
    input  wire logic [5:0]    s_index,
    input  wire logic          m_tready,
    output logic               m_tvalid,
    output logic [1:0]         m_status,
    input  wire cbse_flags_t   flags,
    output cbse_cmd_t          cmd,
    output logic [AW-1:0]      rd_addr,
    output logic [AW-1:0]      wr_addr
);

    cbse_state_t  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          grad_reg, grad_next;
    logic [1:0]    pass_reg, pass_next;
    logic [1:0]    axis_reg, axis_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [2:0]    step_reg, step_next;
    cbse_status_t  status_reg, status_next;
    logic          m_tvalid_reg, m_tvalid_next;
    cbse_status_t  m_status_reg, m_status_next;

    logic [CW-1:0] last_c, cur_c, prev_c, next_c, seg_next_c;
    logic [1:0]    pos_c;

    always_comb begin
        last_c = count_reg - CW'(1);
        case (pass_reg)
            2'd0:    cur_c = count_reg - CW'(2);
            2'd1:    cur_c = last_c;
            default: cur_c = '0;
        endcase
        prev_c     = (cur_c == '0) ? last_c : cur_c - CW'(1);
        next_c     = (cur_c == last_c) ? '0 : cur_c + CW'(1);
        seg_next_c = (CW'(idx_reg) == last_c) ? '0 : CW'(idx_reg) + CW'(1);
        // Interpolation slot: three at the first level, two at the second, one at the last.
        case (step_reg)
            3'd0, 3'd1, 3'd2: pos_c = step_reg[1:0];
            3'd3:             pos_c = 2'd0;
            3'd4:             pos_c = 2'd1;
            default:          pos_c = 2'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        idx_reg      <= idx_next;
        grad_reg     <= grad_next;
        pass_reg     <= pass_next;
        axis_reg     <= axis_next;
        cnt_reg      <= cnt_next;
        step_reg     <= step_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        grad_next     = grad_reg;
        pass_next     = pass_reg;
        axis_next     = axis_reg;
        cnt_next      = cnt_reg;
        step_next     = step_reg;
        status_next   = status_reg;
        m_status_next = m_status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.axis      = axis_reg;
        cmd.pos       = pos_c;
        cmd.grad      = grad_reg;
        rd_addr       = '0;
        wr_addr       = '0;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    idx_next    = AW'(s_index);
                    grad_next   = (cbse_op_t'(s_op) == OP_GRADIENT);
                    status_next = ST_OK;
                    axis_next   = '0;
                    pass_next   = '0;
                    state_next  = S_FINISH;
                    case (cbse_op_t'(s_op))
                        OP_INSERT: begin
                            if (count_reg == CW'(MAX_POINTS)) begin
                                status_next = ST_FULL;
                            end else begin
                                state_next = S_INS_WR;
                            end
                        end
                        OP_MOVE, OP_SET_CTL, OP_EVAL, OP_GRADIENT: begin
                            if (CMPW'(s_index) >= CMPW'(count_reg)) begin
                                status_next = ST_BAD_INDEX;
                            end else if (cbse_op_t'(s_op) == OP_MOVE) begin
                                state_next = S_MOVE_WR;
                            end else if (cbse_op_t'(s_op) == OP_SET_CTL) begin
                                state_next = S_SC_RD;
                            end else begin
                                state_next = S_EV_RD_A;
                            end
                        end
                        default: state_next = S_FINISH;
                    endcase
                end
            end
            S_INS_WR: begin
                cmd.pt_we    = 1'b1;
                cmd.ctl_we   = 1'b1;
                cmd.ctl_wsel = CW_ZERO;
                wr_addr      = AW'(count_reg);
                count_next   = count_reg + CW'(1);
                state_next   = (count_reg != '0) ? S_RC_RD_PREV : S_FINISH;
            end
            S_MOVE_WR: begin
                cmd.pt_we  = 1'b1;
                wr_addr    = idx_reg;
                state_next = S_FINISH;
            end
            S_SC_RD: begin
                cmd.rd_en  = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_SC_WR;
            end
            S_SC_WR: begin
                cmd.ctl_we   = 1'b1;
                cmd.ctl_wsel = CW_SETC;
                wr_addr      = idx_reg;
                state_next   = S_FINISH;
            end
            S_EV_RD_A: begin
                cmd.rd_en  = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_EV_RD_B;
            end
            S_EV_RD_B: begin
                cmd.hold   = 1'b1;
                cmd.rd_en  = 1'b1;
                rd_addr    = AW'(seg_next_c);
                state_next = S_EV_LOAD;
            end
            S_EV_LOAD: begin
                cmd.ev_load = 1'b1;
                step_next   = '0;
                state_next  = S_EV_DIFF;
            end
            S_EV_DIFF: begin
                cmd.ev_diff = 1'b1;
                state_next  = S_EV_MUL;
            end
            S_EV_MUL: begin
                cmd.ev_mul = 1'b1;
                state_next = S_EV_ADD;
            end
            S_EV_ADD: begin
                cmd.ev_add = 1'b1;
                // The gradient stops after the second level.
                if (step_reg == 3'd5 || (grad_reg && step_reg == 3'd4)) begin
                    state_next = S_EV_STORE;
                end else begin
                    step_next  = step_reg + 3'd1;
                    state_next = S_EV_DIFF;
                end
            end
            S_EV_STORE: begin
                cmd.ev_store = 1'b1;
                if (axis_reg == 2'd2) begin
                    state_next = S_FINISH;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_EV_LOAD;
                end
            end
            S_RC_RD_PREV: begin
                cmd.rd_en  = 1'b1;
                rd_addr    = AW'(prev_c);
                state_next = S_RC_RD_NEXT;
            end
            S_RC_RD_NEXT: begin
                cmd.hold   = 1'b1;
                cmd.rd_en  = 1'b1;
                rd_addr    = AW'(next_c);
                state_next = S_RC_DIFF;
            end
            S_RC_DIFF: begin
                cmd.rc_diff = 1'b1;
                state_next  = S_RC_NORM;
            end
            S_RC_NORM: begin
                if (flags.zero) begin
                    state_next = S_RC_WR;
                end else if (flags.rsh) begin
                    cmd.norm_rsh = 1'b1;
                end else if (flags.lsh) begin
                    cmd.norm_lsh = 1'b1;
                end else begin
                    axis_next  = '0;
                    state_next = S_RC_SQ_MUL;
                end
            end
            S_RC_SQ_MUL: begin
                cmd.sq_mul = 1'b1;
                state_next = S_RC_SQ_ACC;
            end
            S_RC_SQ_ACC: begin
                cmd.sq_acc = 1'b1;
                if (axis_reg == 2'd2) begin
                    state_next = S_RC_SQRT_INIT;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_RC_SQ_MUL;
                end
            end
            S_RC_SQRT_INIT: begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_RC_SQRT;
            end
            S_RC_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    axis_next  = '0;
                    state_next = S_RC_DIV_INIT;
                end
            end
            S_RC_DIV_INIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_RC_DIV;
            end
            S_RC_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16) begin
                    state_next = S_RC_DIV_END;
                end
            end
            S_RC_DIV_END: begin
                cmd.div_end = 1'b1;
                if (axis_reg == 2'd2) begin
                    state_next = S_RC_WR;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_RC_DIV_INIT;
                end
            end
            S_RC_WR: begin
                cmd.ctl_we   = 1'b1;
                cmd.ctl_wsel = CW_UNIT;
                wr_addr      = AW'(cur_c);
                if (pass_reg == 2'd2) begin
                    state_next = S_FINISH;
                end else begin
                    pass_next  = pass_reg + 2'd1;
                    state_next = S_RC_RD_PREV;
                end
            end
            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_status = m_status_reg;

endmodule

`default_nettype wire

/* design/closed_bezier_spline_evaluator_core.sv */
// A later insert recomputes three controls one after another; for a zero direction the
// normalize, square, root and divide steps are skipped and a zero control is written.
// One item is in work at a time; the next transfer is taken in the cycle its predecessor's
// result is registered, even while it waits. Synchronous active-low reset empties the table.
`default_nettype none

module closed_bezier_spline_evaluator_core import cbse_pkg::*; #(
    parameter int MAX_POINTS    = CBSE_MAX_POINTS,
    parameter int FRACTION_BITS = CBSE_FRACTION_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // index[5:0], fraction[21:6], in_x[53:22], in_y[85:54], in_z[117:86], zero pad
    input  wire logic [119:0] s_tdata,
    // op[2:0]
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], status[97:96], zero pad
    output logic [103:0]      m_tdata
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    cbse_cmd_t     cmd;
    cbse_flags_t   flags;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [1:0]    m_status;
    logic [31:0]   out_x, out_y, out_z;

    cbse_ctrl #(
        .MAX_POINTS(MAX_POINTS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .s_index  (s_tdata[5:0]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_status (m_status),
        .flags    (flags),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    cbse_dp #(
        .MAX_POINTS    (MAX_POINTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk       (aclk),
        .s_fraction (s_tdata[21:6]),
        .s_x        (s_tdata[53:22]),
        .s_y        (s_tdata[85:54]),
        .s_z        (s_tdata[117:86]),
        .cmd        (cmd),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .flags      (flags),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z)
    );

    assign m_tdata = {6'b0, m_status, out_z, out_y, out_x};

endmodule

`default_nettype wire

/* design/cbse_checker.sv */
`default_nettype none

module cbse_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata
);

    // The block holds one item at a time, so it cannot take two transfers in a row.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[97:96] != 2'd3)
        else $error("undefined status code");

    // A rejected item carries no coordinates.
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[97:96] != 2'd0 |-> m_tdata[95:0] == 96'd0)
        else $error("coordinates on an error result");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind closed_bezier_spline_evaluator_core cbse_checker u_cbse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/closed_bezier_spline_evaluator_core_tb.sv */
`default_nettype none

module closed_bezier_spline_evaluator_core_tb;
    import cbse_pkg::*;

    typedef struct {
        logic [31:0]  x;
        logic [31:0]  y;
        logic [31:0]  z;
        cbse_status_t status;
    } spline_result_t;

    typedef struct {
        logic [2:0]     op;
        logic [5:0]     index;
        logic [15:0]    fraction;
        logic [31:0]    in_x;
        logic [31:0]    in_y;
        logic [31:0]    in_z;
        bit             fixed;
        spline_result_t result;
    } directed_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;

    closed_bezier_spline_evaluator_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predicted state of the spline.
    int             point_x [CBSE_MAX_POINTS];
    int             point_y [CBSE_MAX_POINTS];
    int             point_z [CBSE_MAX_POINTS];
    int             ctl_x   [CBSE_MAX_POINTS];
    int             ctl_y   [CBSE_MAX_POINTS];
    int             ctl_z   [CBSE_MAX_POINTS];
    int             point_count;

    spline_result_t expected_results[$];
    spline_result_t fixed_results[$];
    bit             directed_kinds[$];
    int             error_count;
    int             result_count;
    int             eval_count;
    int             full_count;
    int             bad_index_count;
    int             tx_idle;
    int             rx_idle;
    int             hold_cycles;
    directed_row_t  directed_rows[$];

    initial begin
        aclk = 1'b0;
    end

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bit_w;
        root  = 0;
        bit_w = 64'h1 << 62;
        while (bit_w > n) begin
            bit_w = bit_w >> 2;
        end
        while (bit_w != 0) begin
            if (n >= root + bit_w) begin
                n    = n - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    // Sets the control of one point to the unit direction from its previous
    // to its next neighbour, with cyclic indexing.
    task automatic recompute_tangent(input int i);
        int              n;
        int              prv;
        int              nxt;
        int              cur;
        int              k;
        longint          v[3];
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned len;
        longint          q[3];
        n   = point_count;
        prv = (i + n - 1) % n;
        cur = i % n;
        nxt = (i + 1) % n;
        v[0] = longint'(point_x[nxt]) - longint'(point_x[prv]);
        v[1] = longint'(point_y[nxt]) - longint'(point_y[prv]);
        v[2] = longint'(point_z[nxt]) - longint'(point_z[prv]);
        mx = 0;
        for (k = 0; k < 3; k++) begin
            m[k] = (v[k] < 0) ? longint'(-v[k]) : longint'(v[k]);
            if (m[k] > mx) begin
                mx = m[k];
            end
            q[k] = 0;
        end
        if (mx != 0) begin
            while (mx >= (64'h1 << 30)) begin
                mx = mx >> 1;
                for (k = 0; k < 3; k++) m[k] = m[k] >> 1;
            end
            while (mx < (64'h1 << 29)) begin
                mx = mx << 1;
                for (k = 0; k < 3; k++) m[k] = m[k] << 1;
            end
            sum = 0;
            for (k = 0; k < 3; k++) sum += m[k] * m[k];
            len = int_sqrt(sum);
            for (k = 0; k < 3; k++) begin
                q[k] = longint'((m[k] * 65536 + len / 2) / len);
                if (v[k] < 0) begin
                    q[k] = -q[k];
                end
            end
        end
        ctl_x[cur] = int'(q[0]);
        ctl_y[cur] = int'(q[1]);
        ctl_z[cur] = int'(q[2]);
    endtask

    function automatic longint lerp_round(longint a, longint b, longint t);
        return a + (((b - a) * t + 64'sd32768) >>> CBSE_FRACTION_BITS);
    endfunction

    function automatic logic [31:0] bezier_axis(longint a0, longint c0, longint a1,
                                                longint c1, longint t, bit grad);
        longint q0;
        longint q1;
        longint q2;
        longint r0;
        longint r1;
        q0 = lerp_round(a0, a0 + c0, t);
        q1 = lerp_round(a0 + c0, a1 - c1, t);
        q2 = lerp_round(a1 - c1, a1, t);
        r0 = lerp_round(q0, q1, t);
        r1 = lerp_round(q1, q2, t);
        return grad ? sat_word(r1 - r0) : sat_word(lerp_round(r0, r1, t));
    endfunction

    task automatic spline_predict(input logic [2:0] op, input logic [5:0] idx,
                                  input logic [15:0] frac, input logic [31:0] x,
                                  input logic [31:0] y, input logic [31:0] z,
                                  output spline_result_t res);
        int     n;
        int     j;
        longint t;
        res = '{x: 32'd0, y: 32'd0, z: 32'd0, status: ST_OK};
        t = longint'(frac);
        if (op == OP_INSERT) begin
            if (point_count >= CBSE_MAX_POINTS) begin
                res.status = ST_FULL;
            end else begin
                n = point_count;
                point_x[n] = x;
                point_y[n] = y;
                point_z[n] = z;
                ctl_x[n] = 0;
                ctl_y[n] = 0;
                ctl_z[n] = 0;
                point_count = n + 1;
                if (point_count > 1) begin
                    recompute_tangent(point_count - 2);
                    recompute_tangent(point_count - 1);
                    recompute_tangent(point_count);
                end
            end
        end else if (op >= OP_MOVE && op <= OP_GRADIENT) begin
            if (int'(idx) >= point_count) begin
                res.status = ST_BAD_INDEX;
            end else if (op == OP_MOVE) begin
                point_x[idx] = x;
                point_y[idx] = y;
                point_z[idx] = z;
            end else if (op == OP_SET_CTL) begin
                ctl_x[idx] = int'(sat_word(longint'(signed'(x)) - point_x[idx]));
                ctl_y[idx] = int'(sat_word(longint'(signed'(y)) - point_y[idx]));
                ctl_z[idx] = int'(sat_word(longint'(signed'(z)) - point_z[idx]));
            end else begin
                j = (int'(idx) + 1) % point_count;
                res.x = bezier_axis(point_x[idx], ctl_x[idx], point_x[j], ctl_x[j], t,
                                    op == OP_GRADIENT);
                res.y = bezier_axis(point_y[idx], ctl_y[idx], point_y[j], ctl_y[j], t,
                                    op == OP_GRADIENT);
                res.z = bezier_axis(point_z[idx], ctl_z[idx], point_z[j], ctl_z[j], t,
                                    op == OP_GRADIENT);
            end
        end
    endtask

    // Input transfers feed the predictor; output transfers are checked in order.
    always @(posedge aclk) begin
        spline_result_t pred;
        spline_result_t got;
        spline_result_t want;
        if (aresetn && s_tvalid && s_tready) begin
            spline_predict(s_tuser, s_tdata[5:0], s_tdata[21:6], s_tdata[53:22],
                           s_tdata[85:54], s_tdata[117:86], pred);
            if (directed_kinds.size() > 0) begin
                if (directed_kinds.pop_front()) begin
                    pred = fixed_results.pop_front();
                end
            end
            expected_results = {expected_results, pred};
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.x      = m_tdata[31:0];
            got.y      = m_tdata[63:32];
            got.z      = m_tdata[95:64];
            got.status = cbse_status_t'(m_tdata[97:96]);
            result_count++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                    got.status !== want.status) begin
                    $display("%0t: mismatch expected x=%h y=%h z=%h st=%0d",
                             $time, want.x, want.y, want.z, want.status);
                    $display("%0t:          actual   x=%h y=%h z=%h st=%0d",
                             $time, got.x, got.y, got.z, got.status);
                    error_count++;
                end
                if (want.status == ST_FULL) full_count++;
                if (want.status == ST_BAD_INDEX) bad_index_count++;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Returns at the rising edge at which the item is transferred.
    task automatic send_item(input logic [2:0] op, input logic [5:0] idx,
                             input logic [15:0] frac, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        int gap;
        if ($urandom_range(99) < tx_idle) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, z, y, x, frac, idx};
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    function automatic logic [31:0] random_coord();
        int r;
        r = $urandom_range(99);
        if (r < 3) return 32'h7FFF_FFFF;
        if (r < 6) return 32'h8000_0000;
        if (r < 8) return 32'h0000_0000;
        if (r < 50) return $urandom_range(32'h001F_FFFF) - 32'h0010_0000;
        return $urandom;
    endfunction

    function automatic directed_row_t fixed_row(logic [2:0] op, logic [5:0] idx,
                                                logic [15:0] frac, logic [31:0] x,
                                                logic [31:0] y, logic [31:0] z,
                                                logic [31:0] rx, logic [31:0] ry,
                                                logic [31:0] rz, cbse_status_t st);
        directed_row_t row;
        row = '{op, idx, frac, x, y, z, 1'b1, '{rx, ry, rz, st}};
        return row;
    endfunction

    function automatic directed_row_t free_row(logic [2:0] op, logic [5:0] idx,
                                               logic [15:0] frac, logic [31:0] x,
                                               logic [31:0] y, logic [31:0] z);
        directed_row_t row;
        row = '{op, idx, frac, x, y, z, 1'b0, '{32'd0, 32'd0, 32'd0, ST_OK}};
        return row;
    endfunction

    task automatic add_row(input directed_row_t row);
        directed_rows = {directed_rows, row};
    endtask

    initial begin
        int          item;
        int          r;
        int          waited;
        logic [2:0]  op;
        logic [5:0]  idx;
        error_count = 0;
        result_count = 0;
        eval_count = 0;
        full_count = 0;
        bad_index_count = 0;
        point_count = 0;
        hold_cycles = 0;
        tx_idle = 34;
        rx_idle = 59;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_INSERT;
        aresetn = 1'b0;

        // Empty table, unknown ops, a lone extreme point and a second one.
        add_row(fixed_row(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, ST_BAD_INDEX));
        add_row(fixed_row(OP_GRADIENT, 5, 16'hFFFF, 0, 0, 0, 0, 0, 0, ST_BAD_INDEX));
        add_row(fixed_row(OP_MOVE, 0, 0, 1, 2, 3, 0, 0, 0, ST_BAD_INDEX));
        add_row(fixed_row(OP_SET_CTL, 0, 0, 1, 2, 3, 0, 0, 0, ST_BAD_INDEX));
        add_row(fixed_row(3'd5, 63, 16'hFFFF, '1, '1, '1, 0, 0, 0, ST_OK));
        add_row(fixed_row(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        add_row(fixed_row(OP_INSERT, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                          0, 0, 0, 0, ST_OK));
        add_row(fixed_row(OP_EVAL, 0, 0, 0, 0, 0, 32'h7FFF_FFFF,
                          32'h8000_0000, 0, ST_OK));
        add_row(fixed_row(OP_GRADIENT, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        add_row(fixed_row(OP_EVAL, 1, 0, 0, 0, 0, 0, 0, 0, ST_BAD_INDEX));
        add_row(fixed_row(OP_INSERT, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'hFFFF_FFFF, 0, 0, 0, ST_OK));
        add_row(free_row(OP_EVAL, 1, 16'hFFFF, 0, 0, 0));
        add_row(free_row(OP_GRADIENT, 0, 16'h8000, 0, 0, 0));
        // Control from the opposite extreme saturates.
        add_row(fixed_row(OP_SET_CTL, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 0, 0, 0, ST_OK));
        add_row(free_row(OP_EVAL, 1, 16'h0001, 0, 0, 0));
        add_row(free_row(OP_GRADIENT, 1, 16'hFFFF, 0, 0, 0));
        add_row(fixed_row(OP_MOVE, 1, 0, 32'h0001_0000, 32'hFFFF_0000,
                          32'h0002_0000, 0, 0, 0, ST_OK));
        add_row(free_row(OP_EVAL, 0, 16'hFFFF, 0, 0, 0));
        add_row(free_row(OP_INSERT, 0, 0, 0, 0, 0));
        add_row(free_row(OP_INSERT, 0, 0, 32'h0003_0000, 32'h0001_0000, 0));
        add_row(free_row(OP_EVAL, 3, 16'h4000, 0, 0, 0));
        add_row(free_row(OP_GRADIENT, 2, 16'hC000, 0, 0, 0));
        add_row(fixed_row(OP_MOVE, 63, 0, 0, 0, 0, 0, 0, 0, ST_BAD_INDEX));
        add_row(fixed_row(3'd6, 4, 16'h1234, 0, 0, 0, 0, 0, 0, ST_OK));

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Each directed transfer takes its kind from the front of a queue, so the
        // entry for the next row never gets ahead of the one being accepted.
        foreach (directed_rows[i]) begin
            directed_kinds = {directed_kinds, directed_rows[i].fixed};
            if (directed_rows[i].fixed) begin
                fixed_results = {fixed_results, directed_rows[i].result};
            end
            send_item(directed_rows[i].op, directed_rows[i].index,
                      directed_rows[i].fraction, directed_rows[i].in_x,
                      directed_rows[i].in_y, directed_rows[i].in_z);
        end

        for (item = 0; item < 1650; item++) begin
            if (item == 550 || item == 1100) begin
                // Let the block drain before the idling pattern changes.
                @(negedge aclk);
                s_tvalid <= 1'b0;
                wait (expected_results.size() == 0);
                @(posedge aclk);
                tx_idle = (item == 550) ? 59 : 0;
                rx_idle = (item == 550) ? 34 : 0;
            end
            if (item == 300) begin
                hold_cycles = 1500;
            end
            r = $urandom_range(99);
            if (point_count > 0) begin
                idx = 6'($urandom_range(point_count - 1));
            end else begin
                idx = 0;
            end
            if (r < 10) begin
                op = OP_INSERT;
            end else if (r < 20) begin
                op = OP_MOVE;
            end else if (r < 28) begin
                op = OP_SET_CTL;
            end else if (r < 60) begin
                op = OP_EVAL;
            end else if (r < 90) begin
                op = OP_GRADIENT;
            end else if (r < 96) begin
                op = 3'($urandom_range(OP_MOVE, OP_GRADIENT));
                idx = 6'($urandom);
            end else begin
                op = 3'($urandom_range(5, 7));
                idx = 6'($urandom);
            end
            if (op == OP_EVAL || op == OP_GRADIENT) eval_count++;
            send_item(op, idx, 16'($urandom), random_coord(), random_coord(),
                      random_coord());
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (500) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
            error_count++;
        end
        $display("Checked %0d results, %0d of them curve queries, with %0d points loaded.",
                 result_count, eval_count, point_count);
        $display("Table-full rejections: %0d, out-of-range index rejections: %0d.",
                 full_count, bad_index_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
